FILE: hdl/unsorted_min_priority_queue_assert.svh
// assertion macros for the unsorted min priority queue
// no dependencies; taken by include in the top module, which checks itself
`ifndef UNSORTED_MIN_PRIORITY_QUEUE_ASSERT_SVH
`define UNSORTED_MIN_PRIORITY_QUEUE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// clocked check, off while reset is held
`define UMPQ_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("umpq check failed");
// clocked check, also active during reset
`define UMPQ_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) else $error("umpq check failed");
`else
`define UMPQ_ASSERT(lbl, clk, rstn, prop)
`define UMPQ_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

FILE: hdl/umpq_pkg.sv
// types and constants of the unsorted min priority queue
// no dependencies
`timescale 1ns / 1ps
package umpq_pkg;

    localparam int DEPTH_DEFAULT = 64;

    typedef enum logic [1:0] {
        REQ_ENQ = 2'd0,
        REQ_DEQ = 2'd1,
        REQ_CHG = 2'd2,
        REQ_CLR = 2'd3
    } t_req;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_LOAD,
        OP_SHIFT,
        OP_LOWER
    } t_cell_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_APPLY,
        ST_SETTLE,
        ST_OUT
    } t_state;

    // command broadcast to every cell
    typedef struct packed {
        t_cell_op           op;
        logic        [31:0] tag;
        logic signed [31:0] prio;
    } t_cell_cmd;

    // running scan result handed from cell to cell
    typedef struct packed {
        logic               has_min;
        logic        [31:0] min_tag;
        logic signed [31:0] min_prio;
        logic               hit;
    } t_carry;

endpackage

FILE: hdl/umpq_if.sv
// request and result channel interfaces of the unsorted min priority queue
// no dependencies
`timescale 1ns / 1ps
interface umpq_in_if;
    logic               valid;
    logic               ready;
    logic        [1:0]  req_type;
    logic        [31:0] value_tag;
    logic signed [31:0] prio_in;
    modport source (output valid, req_type, value_tag, prio_in, input ready);
    modport sink   (input valid, req_type, value_tag, prio_in, output ready);
endinterface

interface umpq_out_if;
    logic               valid;
    logic               ready;
    logic        [31:0] out_tag;
    logic        [1:0]  status;
    logic        [6:0]  entry_count;
    logic               is_empty;
    logic        [31:0] head_tag;
    logic signed [31:0] head_prio;
    modport source (output valid, out_tag, status, entry_count, is_empty, head_tag,
                    head_prio, input ready);
    modport sink   (input valid, out_tag, status, entry_count, is_empty, head_tag,
                    head_prio, output ready);
endinterface

FILE: hdl/umpq_cell.sv
// one slot of the queue: holds an entry and adds it to the running scan
// depends on umpq_pkg
`timescale 1ns / 1ps
module umpq_cell #(
    parameter int DEPTH = 64,
    parameter int IW    = 6,
    parameter int CW    = 7,
    parameter int IDX   = 0
) (
    input  logic                  i_clk,
    input  umpq_pkg::t_cell_cmd   i_cmd,
    input  logic [IW-1:0]         i_sel,
    input  logic [CW-1:0]         i_count,
    input  logic [31:0]           i_key,
    input  logic [31:0]           i_nxt_tag,
    input  logic signed [31:0]    i_nxt_prio,
    input  umpq_pkg::t_carry      i_carry,
    input  logic [IW-1:0]         i_min_idx,
    input  logic [IW-1:0]         i_hit_idx,
    output logic [31:0]           o_tag,
    output logic signed [31:0]    o_prio,
    output umpq_pkg::t_carry      o_carry,
    output logic [IW-1:0]         o_min_idx,
    output logic [IW-1:0]         o_hit_idx
);
    import umpq_pkg::*;

    localparam logic [IW-1:0] MY_IDX  = IW'(IDX);
    localparam logic [CW-1:0] MY_CNT  = CW'(IDX);
    localparam logic [CW-1:0] NXT_CNT = CW'(IDX + 1);

    logic [31:0]        r_tag;
    logic signed [31:0] r_prio;
    t_carry             r_carry, n_carry;
    logic [IW-1:0]      r_min_idx, n_min_idx;
    logic [IW-1:0]      r_hit_idx, n_hit_idx;
    logic               w_occ;

    assign w_occ = (MY_CNT < i_count);

    // fold this slot into the scan
    always_comb begin
        n_carry   = i_carry;
        n_min_idx = i_min_idx;
        n_hit_idx = i_hit_idx;
        if (w_occ && (!i_carry.has_min || (r_prio < i_carry.min_prio))) begin
            n_carry.has_min  = 1'b1;
            n_carry.min_tag  = r_tag;
            n_carry.min_prio = r_prio;
            n_min_idx        = MY_IDX;
        end
        if (w_occ && !i_carry.hit && (r_tag == i_key)) begin
            n_carry.hit = 1'b1;
            n_hit_idx   = MY_IDX;
        end
    end

    always_ff @(posedge i_clk) begin
        r_carry   <= n_carry;
        r_min_idx <= n_min_idx;
        r_hit_idx <= n_hit_idx;
    end

    // slot contents
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_LOAD: begin
                if (i_sel == MY_IDX) begin
                    r_tag  <= i_cmd.tag;
                    r_prio <= i_cmd.prio;
                end
            end
            OP_SHIFT: begin
                if ((MY_IDX >= i_sel) && (NXT_CNT < i_count)) begin
                    r_tag  <= i_nxt_tag;
                    r_prio <= i_nxt_prio;
                end
            end
            OP_LOWER: begin
                if ((i_sel == MY_IDX) && (i_cmd.prio < r_prio)) begin
                    r_prio <= i_cmd.prio;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_tag     = r_tag;
    assign o_prio    = r_prio;
    assign o_carry   = r_carry;
    assign o_min_idx = r_min_idx;
    assign o_hit_idx = r_hit_idx;
endmodule

FILE: hdl/unsorted_min_priority_queue.sv
// enqueue and clear go straight to the apply step; dequeue and change first wait for the
// scan that ripples through the row of DEPTH slot cells one cell per cycle; all then settle
// before the result beat; one request at a time.
// reset: synchronous active low, empties the queue; slot contents are not cleared.
// top level: sequencer plus a row of slot cells; depends on umpq_pkg, umpq_if, umpq_cell, assert header
`timescale 1ns / 1ps
`include "unsorted_min_priority_queue_assert.svh"
module unsorted_min_priority_queue #(
    parameter int DEPTH = umpq_pkg::DEPTH_DEFAULT
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    umpq_in_if.sink      i_in,
    umpq_out_if.source   o_out
);
    import umpq_pkg::*;

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
    localparam logic [CW-1:0] LAST_IDX = CW'(DEPTH - 1);

    t_state             r_state, n_state;
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      r_wait;
    t_req               r_req;
    logic [31:0]        r_key;
    logic signed [31:0] r_prio;
    logic [31:0]        r_out_tag;
    logic [1:0]         r_status;
    logic [31:0]        r_head_tag;
    logic signed [31:0] r_head_prio;

    t_cell_cmd          w_cmd;
    logic [IW-1:0]      w_sel;
    logic [CW-1:0]      w_new_count;
    logic [1:0]         w_status;
    logic [31:0]        w_out_tag;
    logic [CW+6:0]      w_cnt_ext;

    logic [31:0]        w_tag    [DEPTH];
    logic signed [31:0] w_sprio  [DEPTH];
    t_carry             w_carry  [DEPTH+1];
    logic [IW-1:0]      w_minix  [DEPTH+1];
    logic [IW-1:0]      w_hitix  [DEPTH+1];

    assign w_carry[0] = '0;
    assign w_minix[0] = '0;
    assign w_hitix[0] = '0;

    // row of slot cells
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [31:0]        w_nt;
        logic signed [31:0] w_np;
        if (g + 1 < DEPTH) begin : g_nb
            assign w_nt = w_tag[g+1];
            assign w_np = w_sprio[g+1];
        end else begin : g_end
            assign w_nt = '0;
            assign w_np = '0;
        end
        umpq_cell #(.DEPTH(DEPTH), .IW(IW), .CW(CW), .IDX(g)) u_cell (
            .i_clk      (i_clk),
            .i_cmd      (w_cmd),
            .i_sel      (w_sel),
            .i_count    (r_count),
            .i_key      (r_key),
            .i_nxt_tag  (w_nt),
            .i_nxt_prio (w_np),
            .i_carry    (w_carry[g]),
            .i_min_idx  (w_minix[g]),
            .i_hit_idx  (w_hitix[g]),
            .o_tag      (w_tag[g]),
            .o_prio     (w_sprio[g]),
            .o_carry    (w_carry[g+1]),
            .o_min_idx  (w_minix[g+1]),
            .o_hit_idx  (w_hitix[g+1])
        );
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    if ((t_req'(i_in.req_type) == REQ_DEQ) ||
                        (t_req'(i_in.req_type) == REQ_CHG)) begin
                        n_state = ST_SCAN;
                    end else begin
                        n_state = ST_APPLY;
                    end
                end
            end
            ST_SCAN:   if (r_wait == '0) n_state = ST_APPLY;
            ST_APPLY:  n_state = ST_SETTLE;
            ST_SETTLE: if (r_wait == '0) n_state = ST_OUT;
            ST_OUT:    if (o_out.ready) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // apply step: cell command, status, output tag and new count
    always_comb begin
        w_cmd       = '{op: OP_NONE, tag: r_key, prio: r_prio};
        w_sel       = '0;
        w_new_count = r_count;
        w_status    = STATUS_OK;
        w_out_tag   = '0;
        if (r_state == ST_APPLY) begin
            unique case (r_req)
                REQ_ENQ: begin
                    if (r_count == FULL_CNT) begin
                        w_status = STATUS_FULL;
                    end else begin
                        w_cmd.op    = OP_LOAD;
                        w_sel       = r_count[IW-1:0];
                        w_new_count = r_count + 1'b1;
                    end
                end
                REQ_DEQ: begin
                    if (r_count == '0) begin
                        w_status = STATUS_EMPTY;
                    end else begin
                        w_cmd.op    = OP_SHIFT;
                        w_sel       = w_minix[DEPTH];
                        w_out_tag   = w_carry[DEPTH].min_tag;
                        w_new_count = r_count - 1'b1;
                    end
                end
                REQ_CHG: begin
                    if (r_count == '0) begin
                        w_status = STATUS_EMPTY;
                    end else if (w_carry[DEPTH].hit) begin
                        w_cmd.op = OP_LOWER;
                        w_sel    = w_hitix[DEPTH];
                    end
                end
                REQ_CLR: w_new_count = '0;
                default: begin
                end
            endcase
        end
    end

    // control registers; the settle wait is longer than the scan wait, since slot 0 changes
    // at the apply edge and its scan register only picks that up after it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_wait  <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_APPLY) r_count <= w_new_count;
            if (r_state == ST_IDLE) begin
                r_wait <= LAST_IDX;
            end else if (r_state == ST_APPLY) begin
                r_wait <= FULL_CNT;
            end else if (r_wait != '0) begin
                r_wait <= r_wait - 1'b1;
            end
        end
    end

    // request and result payload
    always_ff @(posedge i_clk) begin
        if ((r_state == ST_IDLE) && i_in.valid) begin
            r_req  <= t_req'(i_in.req_type);
            r_key  <= i_in.value_tag;
            r_prio <= i_in.prio_in;
        end
        if (r_state == ST_APPLY) begin
            r_status  <= w_status;
            r_out_tag <= w_out_tag;
        end
        if ((r_state == ST_SETTLE) && (r_wait == '0)) begin
            if (r_count != '0) begin
                r_head_tag  <= w_carry[DEPTH].min_tag;
                r_head_prio <= w_carry[DEPTH].min_prio;
            end else begin
                r_head_tag  <= '0;
                r_head_prio <= '0;
            end
        end
    end

    assign w_cnt_ext = {7'd0, r_count};

    // handshake and result beat
    always_comb begin
        i_in.ready        = (r_state == ST_IDLE);
        o_out.valid       = (r_state == ST_OUT);
        o_out.out_tag     = r_out_tag;
        o_out.status      = r_status;
        o_out.entry_count = w_cnt_ext[6:0];
        o_out.is_empty    = (r_count == '0);
        o_out.head_tag    = r_head_tag;
        o_out.head_prio   = r_head_prio;
    end

    `UMPQ_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= FULL_CNT)
    `UMPQ_ASSERT(a_one_side, i_clk, i_rst_n, !(i_in.ready && o_out.valid))
    `UMPQ_ASSERT(a_enq_grows, i_clk, i_rst_n,
        (r_state == ST_APPLY && r_req == REQ_ENQ && r_count != FULL_CNT) |=>
        (r_count == $past(r_count) + 1'b1))
    `UMPQ_ASSERT(a_count_held, i_clk, i_rst_n,
        (r_state != ST_APPLY) |=> (r_count == $past(r_count)))
endmodule
